// ===== src/acdn_pkg.sv =====
package acdn_pkg;

  // Field widths fixed by the interface.
  localparam int CW   = 24;  // centre coordinate, signed Q15.8
  localparam int EW   = 22;  // half extent, unsigned Q14.8
  localparam int VW   = 25;  // collision vector component, signed
  localparam int OW   = 26;  // per-axis overlap before truncation, signed
  localparam int DW   = 25;  // depth output
  localparam int SQW  = 64;  // square-root operand and partial root
  localparam int RW   = 32;  // root width
  localparam int QW   = 15;  // quotient magnitude width
  localparam int NW   = 16;  // unit vector component, signed Q1.14
  localparam int REMW = 46;  // divider remainder width
  localparam int FRAC = 20;  // dividend shift for the Q1.14 quotient

  // Pipeline depths.
  localparam int SQRT_CELLS = 32;
  localparam int DIV_CELLS  = QW;

  // Operation codes.
  localparam logic [1:0] OP_VOXEL_PAIR = 2'd0;
  localparam logic [1:0] OP_VOXEL_BOX  = 2'd1;
  localparam logic [1:0] OP_BOX_PAIR   = 2'd2;

  // Axis codes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [OW-1:0] VOXEL_EXT = OW'(256);
  localparam logic [EW:0]   HALF_Q8   = (EW+1)'(128);

  // Values that ride along the square-root chain untouched.
  typedef struct packed {
    logic signed [DW-1:0] depth;
    logic [1:0]           axis;
    logic                 nneg;
    logic [2:0]           sgn;
    logic [VW-1:0]        mag_x;
    logic [VW-1:0]        mag_y;
    logic [VW-1:0]        mag_z;
  } side_t;

  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [QW-1:0]   q;
  } lane_t;

  typedef lane_t [2:0] lanes_t;

  // Values that ride along the divider chain.
  typedef struct packed {
    logic signed [DW-1:0] depth;
    logic [1:0]           axis;
    logic                 nneg;
    logic [2:0]           sgn;
  } tag_t;

endpackage

// ===== src/aabb_contact_depth_normal_unit.sv =====
// Pipeline: 3 front stages, 32 root cells, 15 divider cells and the output
// register lie between an input beat and its result beat.
// Throughput: one beat per cycle; every stage holds one item and the whole
// chain advances together whenever the output register is free or drained.
// Reset (rst_n low, synchronous) clears every stage's valid flag; data
// registers are not reset.
module aabb_contact_depth_normal_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic signed [acdn_pkg::CW-1:0] in_a_x,
  input  logic signed [acdn_pkg::CW-1:0] in_a_y,
  input  logic signed [acdn_pkg::CW-1:0] in_a_z,
  input  logic signed [acdn_pkg::CW-1:0] in_b_x,
  input  logic signed [acdn_pkg::CW-1:0] in_b_y,
  input  logic signed [acdn_pkg::CW-1:0] in_b_z,
  input  logic [acdn_pkg::EW-1:0]       in_ext_x,
  input  logic [acdn_pkg::EW-1:0]       in_ext_y,
  input  logic [acdn_pkg::EW-1:0]       in_ext_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [acdn_pkg::DW-1:0] out_depth,
  output logic [1:0]                    out_normal_axis,
  output logic                          out_normal_negative,
  output logic signed [acdn_pkg::NW-1:0] out_dir_x,
  output logic signed [acdn_pkg::NW-1:0] out_dir_y,
  output logic signed [acdn_pkg::NW-1:0] out_dir_z
);

  localparam int NS = acdn_pkg::SQRT_CELLS;
  localparam int ND = acdn_pkg::DIV_CELLS;

  // The whole pipeline moves as one: it advances whenever the output
  // register is empty or its beat is being taken this cycle.
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Front end: vector, overlaps, axis choice and sum of squares.
  logic                     f_valid;
  logic [acdn_pkg::SQW-1:0] f_x;
  acdn_pkg::side_t          f_side;

  acdn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .op        (in_op),
    .a_x       (in_a_x),
    .a_y       (in_a_y),
    .a_z       (in_a_z),
    .b_x       (in_b_x),
    .b_y       (in_b_y),
    .b_z       (in_b_z),
    .ext_x     (in_ext_x),
    .ext_y     (in_ext_y),
    .ext_z     (in_ext_z),
    .out_valid (f_valid),
    .out_x     (f_x),
    .out_side  (f_side)
  );

  // Square-root chain: each cell settles one root bit, highest first.
  logic                     sq_valid [NS+1];
  logic [acdn_pkg::SQW-1:0] sq_rem   [NS+1];
  logic [acdn_pkg::SQW-1:0] sq_res   [NS+1];
  acdn_pkg::side_t          sq_side  [NS+1];

  assign sq_valid[0] = f_valid;
  assign sq_rem[0]   = f_x;
  assign sq_res[0]   = '0;
  assign sq_side[0]  = f_side;

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    acdn_sqrt_cell #(.K(NS - 1 - g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (sq_valid[g]),
      .in_rem    (sq_rem[g]),
      .in_res    (sq_res[g]),
      .in_side   (sq_side[g]),
      .out_valid (sq_valid[g+1]),
      .out_rem   (sq_rem[g+1]),
      .out_res   (sq_res[g+1]),
      .out_side  (sq_side[g+1])
    );
  end

  // Divider chain: three lanes divide mag << 20 by the root, one quotient
  // bit per cell. The quotient never exceeds 16384, so 15 bits suffice.
  logic                    dv_valid [ND+1];
  logic [acdn_pkg::RW-1:0] dv_root  [ND+1];
  acdn_pkg::lanes_t        dv_lanes [ND+1];
  acdn_pkg::tag_t          dv_tag   [ND+1];
  acdn_pkg::side_t         sq_last;

  assign sq_last     = sq_side[NS];
  assign dv_valid[0] = sq_valid[NS];
  assign dv_root[0]  = sq_res[NS][acdn_pkg::RW-1:0];

  always_comb begin
    dv_lanes[0][0].rem = acdn_pkg::REMW'(sq_last.mag_x) << acdn_pkg::FRAC;
    dv_lanes[0][1].rem = acdn_pkg::REMW'(sq_last.mag_y) << acdn_pkg::FRAC;
    dv_lanes[0][2].rem = acdn_pkg::REMW'(sq_last.mag_z) << acdn_pkg::FRAC;
    dv_lanes[0][0].q   = '0;
    dv_lanes[0][1].q   = '0;
    dv_lanes[0][2].q   = '0;
    dv_tag[0].depth    = sq_last.depth;
    dv_tag[0].axis     = sq_last.axis;
    dv_tag[0].nneg     = sq_last.nneg;
    dv_tag[0].sgn      = sq_last.sgn;
  end

  for (genvar g = 0; g < ND; g++) begin : g_div
    acdn_div_cell #(.J(ND - 1 - g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (dv_valid[g]),
      .in_root   (dv_root[g]),
      .in_lanes  (dv_lanes[g]),
      .in_tag    (dv_tag[g]),
      .out_valid (dv_valid[g+1]),
      .out_root  (dv_root[g+1]),
      .out_lanes (dv_lanes[g+1]),
      .out_tag   (dv_tag[g+1])
    );
  end

  // Output register: quotients take the sign of their vector component.
  acdn_pkg::lanes_t        fin_lanes;
  acdn_pkg::tag_t          fin_tag;
  logic signed [acdn_pkg::DW-1:0] depth_r;
  logic [1:0]              axis_r;
  logic                    nneg_r;
  logic [acdn_pkg::NW-1:0] dir_r [3];

  assign fin_lanes = dv_lanes[ND];
  assign fin_tag   = dv_tag[ND];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      depth_r <= fin_tag.depth;
      axis_r  <= fin_tag.axis;
      nneg_r  <= fin_tag.nneg;
      for (int i = 0; i < 3; i++) begin
        if (fin_tag.sgn[i]) begin
          dir_r[i] <= acdn_pkg::NW'(-{1'b0, fin_lanes[i].q});
        end else begin
          dir_r[i] <= acdn_pkg::NW'({1'b0, fin_lanes[i].q});
        end
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_depth           = depth_r;
  assign out_normal_axis     = axis_r;
  assign out_normal_negative = nneg_r;
  assign out_dir_x           = dir_r[0];
  assign out_dir_y           = dir_r[1];
  assign out_dir_z           = dir_r[2];

`ifndef SYNTH
  // A stalled result must hold the whole chain, including the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while result stalled");

  // A result stays visible until it is taken.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_depth) && $stable(out_dir_x)))
    else $error("stalled result changed");

  // A delivered axis code is always a real axis.
  a_axis_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_normal_axis == acdn_pkg::AXIS_X ||
                   out_normal_axis == acdn_pkg::AXIS_Y ||
                   out_normal_axis == acdn_pkg::AXIS_Z))
    else $error("bad normal axis");

  // The x and y unit vector components stay within plus or minus one in Q1.14.
  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_x <= 16'sd16384 && out_dir_x >= -16'sd16384 &&
                   out_dir_y <= 16'sd16384 && out_dir_y >= -16'sd16384))
    else $error("unit vector out of range");
`endif

endmodule

// ===== src/acdn_front.sv =====
module acdn_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [1:0]                    op,
  input  logic signed [acdn_pkg::CW-1:0] a_x,
  input  logic signed [acdn_pkg::CW-1:0] a_y,
  input  logic signed [acdn_pkg::CW-1:0] a_z,
  input  logic signed [acdn_pkg::CW-1:0] b_x,
  input  logic signed [acdn_pkg::CW-1:0] b_y,
  input  logic signed [acdn_pkg::CW-1:0] b_z,
  input  logic [acdn_pkg::EW-1:0]       ext_x,
  input  logic [acdn_pkg::EW-1:0]       ext_y,
  input  logic [acdn_pkg::EW-1:0]       ext_z,
  output logic                          out_valid,
  output logic [acdn_pkg::SQW-1:0]      out_x,
  output acdn_pkg::side_t               out_side
);

  localparam int VW = acdn_pkg::VW;
  localparam int OW = acdn_pkg::OW;
  localparam int PW = 2 * VW;

  // Stage one: collision vector, magnitudes and overlaps.
  logic signed [VW-1:0] a_e [3];
  logic signed [VW-1:0] b_e [3];
  logic [acdn_pkg::EW-1:0] ext_a [3];
  logic signed [VW-1:0] v [3];
  logic [VW-1:0]        mag [3];
  logic [OW-1:0]        e [3];
  logic                 same;

  logic                 s1_valid_r;
  logic [VW-1:0]        s1_mag_r [3];
  logic signed [OW-1:0] s1_ov_r [3];
  logic [2:0]           s1_pos_r;
  logic [2:0]           s1_neg_r;

  assign a_e[0] = {a_x[acdn_pkg::CW-1], a_x};
  assign a_e[1] = {a_y[acdn_pkg::CW-1], a_y};
  assign a_e[2] = {a_z[acdn_pkg::CW-1], a_z};
  assign b_e[0] = {b_x[acdn_pkg::CW-1], b_x};
  assign b_e[1] = {b_y[acdn_pkg::CW-1], b_y};
  assign b_e[2] = {b_z[acdn_pkg::CW-1], b_z};
  assign ext_a[0] = ext_x;
  assign ext_a[1] = ext_y;
  assign ext_a[2] = ext_z;

  assign same = (a_x == b_x) && (a_y == b_y) && (a_z == b_z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (same) begin
        v[i] = VW'(1);
      end else if (op == acdn_pkg::OP_VOXEL_PAIR) begin
        v[i] = a_e[i] - b_e[i];
      end else begin
        v[i] = b_e[i] - a_e[i];
      end
      mag[i] = v[i][VW-1] ? VW'(-v[i]) : VW'(v[i]);
      case (op)
        acdn_pkg::OP_VOXEL_PAIR: e[i] = acdn_pkg::VOXEL_EXT;
        acdn_pkg::OP_VOXEL_BOX:  e[i] = OW'({1'b0, ext_a[i]} + acdn_pkg::HALF_Q8);
        default:                 e[i] = OW'(ext_a[i]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag_r[i] <= mag[i];
        s1_ov_r[i]  <= $signed(e[i] - OW'(mag[i]));
        s1_pos_r[i] <= !v[i][VW-1] && (v[i] != '0);
        s1_neg_r[i] <= v[i][VW-1];
      end
    end
  end

  // Stage two: axis choice and squares.
  logic [1:0]           axis;
  logic                 s2_valid_r;
  logic [PW-1:0]        s2_sq_r [3];
  acdn_pkg::side_t      s2_side_r;

  always_comb begin
    if (s1_ov_r[0] < s1_ov_r[1] && s1_ov_r[0] < s1_ov_r[2]) begin
      axis = acdn_pkg::AXIS_X;
    end else if (s1_ov_r[1] < s1_ov_r[2]) begin
      axis = acdn_pkg::AXIS_Y;
    end else begin
      axis = acdn_pkg::AXIS_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_sq_r[i] <= PW'(s1_mag_r[i]) * PW'(s1_mag_r[i]);
      end
      case (axis)
        acdn_pkg::AXIS_X: begin
          s2_side_r.depth <= s1_ov_r[0][acdn_pkg::DW-1:0];
          s2_side_r.nneg  <= !s1_pos_r[0];
        end
        acdn_pkg::AXIS_Y: begin
          s2_side_r.depth <= s1_ov_r[1][acdn_pkg::DW-1:0];
          s2_side_r.nneg  <= !s1_pos_r[1];
        end
        default: begin
          s2_side_r.depth <= s1_ov_r[2][acdn_pkg::DW-1:0];
          s2_side_r.nneg  <= !s1_pos_r[2];
        end
      endcase
      s2_side_r.axis  <= axis;
      s2_side_r.sgn   <= s1_neg_r;
      s2_side_r.mag_x <= s1_mag_r[0];
      s2_side_r.mag_y <= s1_mag_r[1];
      s2_side_r.mag_z <= s1_mag_r[2];
    end
  end

  // Stage three: sum of squares, scaled for a root with six extra bits.
  logic s3_valid_r;
  logic [acdn_pkg::SQW-1:0] s3_x_r;
  acdn_pkg::side_t          s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_x_r    <= acdn_pkg::SQW'(PW'(s2_sq_r[0]) + PW'(s2_sq_r[1]) + PW'(s2_sq_r[2])) << 12;
      s3_side_r <= s2_side_r;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_x     = s3_x_r;
  assign out_side  = s3_side_r;

endmodule

// ===== src/acdn_sqrt_cell.sv =====
module acdn_sqrt_cell #(
  parameter int K = 31
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [acdn_pkg::SQW-1:0] in_rem,
  input  logic [acdn_pkg::SQW-1:0] in_res,
  input  acdn_pkg::side_t          in_side,
  output logic                     out_valid,
  output logic [acdn_pkg::SQW-1:0] out_rem,
  output logic [acdn_pkg::SQW-1:0] out_res,
  output acdn_pkg::side_t          out_side
);

  localparam logic [acdn_pkg::SQW-1:0] BIT = acdn_pkg::SQW'(1) << (2 * K);

  logic                     valid_r;
  logic [acdn_pkg::SQW-1:0] rem_r;
  logic [acdn_pkg::SQW-1:0] res_r;
  acdn_pkg::side_t          side_r;
  logic [acdn_pkg::SQW-1:0] trial;

  assign trial = in_res + BIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      if (in_rem >= trial) begin
        rem_r <= in_rem - trial;
        res_r <= (in_res >> 1) + BIT;
      end else begin
        rem_r <= in_rem;
        res_r <= in_res >> 1;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_res   = res_r;
  assign out_side  = side_r;

endmodule

// ===== src/acdn_div_cell.sv =====
module acdn_div_cell #(
  parameter int J = 14
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [acdn_pkg::RW-1:0] in_root,
  input  acdn_pkg::lanes_t        in_lanes,
  input  acdn_pkg::tag_t          in_tag,
  output logic                    out_valid,
  output logic [acdn_pkg::RW-1:0] out_root,
  output acdn_pkg::lanes_t        out_lanes,
  output acdn_pkg::tag_t          out_tag
);

  logic                      valid_r;
  logic [acdn_pkg::RW-1:0]   root_r;
  acdn_pkg::lanes_t          lanes_r;
  acdn_pkg::lanes_t          lanes_nxt;
  acdn_pkg::tag_t            tag_r;
  logic [acdn_pkg::REMW-1:0] dsh;

  assign dsh = acdn_pkg::REMW'(in_root) << J;

  // Each lane settles quotient bit J by a compare and subtract.
  always_comb begin
    lanes_nxt = in_lanes;
    for (int i = 0; i < 3; i++) begin
      if (in_lanes[i].rem >= dsh) begin
        lanes_nxt[i].rem  = in_lanes[i].rem - dsh;
        lanes_nxt[i].q[J] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r  <= in_root;
      tag_r   <= in_tag;
      lanes_r <= lanes_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_root  = root_r;
  assign out_lanes = lanes_r;
  assign out_tag   = tag_r;

endmodule

// ===== sim/tb_aabb_contact_depth_normal_unit.sv =====
module tb_aabb_contact_depth_normal_unit;

  localparam int DW = acdn_pkg::DW;
  localparam int NW = acdn_pkg::NW;
  localparam int CW = acdn_pkg::CW;
  localparam int EW = acdn_pkg::EW;

  // The spare operation code, which behaves as a box pair.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // One expected result beat, held in arrival order.
  typedef struct {
    logic signed [DW-1:0] depth;
    logic [1:0]           axis;
    logic                 neg;
    logic signed [NW-1:0] dx;
    logic signed [NW-1:0] dy;
    logic signed [NW-1:0] dz;
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = acdn_pkg::OP_VOXEL_PAIR;
  logic signed [CW-1:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [CW-1:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic [EW-1:0] in_ext_x = '0, in_ext_y = '0, in_ext_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DW-1:0] out_depth;
  logic [1:0] out_normal_axis;
  logic out_normal_negative;
  logic signed [NW-1:0] out_dir_x, out_dir_y, out_dir_z;

  contact_t pending_contacts[$];
  int fail_count = 0;
  // When set, neither side idles; used for a long stretch of full-rate traffic.
  bit no_idle = 1'b0;

  aabb_contact_depth_normal_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Integer square root by the bit-pair method, on an unsigned 64-bit operand.
  function automatic longint unsigned root_of(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Works out depth, normal and unit vector for one pair of boxes.
  function automatic contact_t contact_of(logic [1:0] op,
                                          logic signed [CW-1:0] a[3],
                                          logic signed [CW-1:0] b[3],
                                          logic [EW-1:0] e[3]);
    contact_t c;
    longint v[3], ov[3], ext;
    longint unsigned mag[3], sq, r, q;
    bit same;
    int ax;
    same = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      // Coincident centres would give no direction, so a tiny diagonal is used.
      if (same) v[i] = 1;
      else if (op == acdn_pkg::OP_VOXEL_PAIR) v[i] = longint'(a[i]) - longint'(b[i]);
      else v[i] = longint'(b[i]) - longint'(a[i]);
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      if (op == acdn_pkg::OP_VOXEL_PAIR) ext = 256;
      else if (op == acdn_pkg::OP_VOXEL_BOX) ext = longint'(e[i]) + 128;
      else ext = longint'(e[i]);
      ov[i] = ext - longint'(mag[i]);
      sq += mag[i] * mag[i];
    end
    // Ties go to y over x, and to z over y.
    if (ov[0] < ov[1] && ov[0] < ov[2]) ax = 0;
    else if (ov[1] < ov[2]) ax = 1;
    else ax = 2;
    c.depth = ov[ax][DW-1:0];
    c.axis = (ax == 0) ? acdn_pkg::AXIS_X : (ax == 1) ? acdn_pkg::AXIS_Y : acdn_pkg::AXIS_Z;
    c.neg = !(v[ax] > 0);
    r = root_of(sq << 12);
    for (int i = 0; i < 3; i++) begin
      q = (r != 0) ? ((mag[i] << acdn_pkg::FRAC) / r) : 0;
      if (v[i] < 0) q = -q;
      if (i == 0) c.dx = q[NW-1:0];
      else if (i == 1) c.dy = q[NW-1:0];
      else c.dz = q[NW-1:0];
    end
    return c;
  endfunction

  // Presents one beat at the falling edge and holds it until accepted. Valid is
  // left high afterwards, so the next call either replaces the beat or idles.
  task automatic send_pair(logic [1:0] op,
                           logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                           logic signed [CW-1:0] az, logic signed [CW-1:0] bx,
                           logic signed [CW-1:0] by, logic signed [CW-1:0] bz,
                           logic [EW-1:0] ex, logic [EW-1:0] ey, logic [EW-1:0] ez);
    logic signed [CW-1:0] a[3], b[3];
    logic [EW-1:0] e[3];
    a = '{ax, ay, az};
    b = '{bx, by, bz};
    e = '{ex, ey, ez};
    while (!no_idle && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_op <= op;
    in_a_x <= ax; in_a_y <= ay; in_a_z <= az;
    in_b_x <= bx; in_b_y <= by; in_b_z <= bz;
    in_ext_x <= ex; in_ext_y <= ey; in_ext_z <= ez;
    in_valid <= 1'b1;
    pending_contacts.push_back(contact_of(op, a, b, e));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver back-pressure, decided at each falling edge.
  always @(negedge clk) out_ready <= no_idle || ($urandom_range(99) >= 26);

  // Compares each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_contacts.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        contact_t c;
        c = pending_contacts.pop_front();
        if (out_depth !== c.depth) begin
          $error("depth: expected %0d, got %0d", c.depth, out_depth); fail_count++;
        end
        if (out_normal_axis !== c.axis) begin
          $error("normal_axis: expected %0d, got %0d", c.axis, out_normal_axis);
          fail_count++;
        end
        if (out_normal_negative !== c.neg) begin
          $error("normal_negative: expected %0d, got %0d", c.neg, out_normal_negative);
          fail_count++;
        end
        if (out_dir_x !== c.dx) begin
          $error("dir_x: expected %0d, got %0d", c.dx, out_dir_x); fail_count++;
        end
        if (out_dir_y !== c.dy) begin
          $error("dir_y: expected %0d, got %0d", c.dy, out_dir_y); fail_count++;
        end
        if (out_dir_z !== c.dz) begin
          $error("dir_z: expected %0d, got %0d", c.dz, out_dir_z); fail_count++;
        end
      end
    end
  end

  function automatic logic signed [CW-1:0] rand_coord();
    return CW'($urandom);
  endfunction

  // A coordinate within 1024 LSB of the given one, wrapping at the field width.
  function automatic logic signed [CW-1:0] near_coord(logic signed [CW-1:0] c);
    return CW'(int'(c) + int'($urandom_range(2048)) - 1024);
  endfunction

  // Corners of the field ranges, every operation, coincident centres and ties.
  task automatic test_directed();
    localparam logic signed [CW-1:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [CW-1:0] CMIN = -24'sh800000;
    localparam logic [EW-1:0] EMAX = 22'h3FFFFF;
    send_pair(acdn_pkg::OP_VOXEL_PAIR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(acdn_pkg::OP_VOXEL_BOX, 5, 5, 5, 5, 5, 5, 7, 8, 9);
    send_pair(acdn_pkg::OP_BOX_PAIR, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, EMAX, EMAX, EMAX);
    send_pair(acdn_pkg::OP_VOXEL_PAIR, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0, 0, 0);
    send_pair(acdn_pkg::OP_VOXEL_PAIR, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, EMAX, EMAX, EMAX);
    send_pair(acdn_pkg::OP_VOXEL_BOX, CMIN, CMAX, 0, CMAX, CMIN, 0, EMAX, 0, EMAX);
    send_pair(acdn_pkg::OP_BOX_PAIR, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0, EMAX, 0);
    send_pair(acdn_pkg::OP_BOX_PAIR, 0, 0, 0, 100, 100, 100, 300, 300, 300);
    send_pair(acdn_pkg::OP_BOX_PAIR, 0, 0, 0, 100, 100, 50, 300, 300, 300);
    send_pair(acdn_pkg::OP_BOX_PAIR, 0, 0, 0, 50, 100, 100, 300, 300, 300);
    send_pair(acdn_pkg::OP_VOXEL_BOX, 0, 0, 0, -100, 50, 50, 300, 300, 300);
    send_pair(acdn_pkg::OP_VOXEL_PAIR, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    send_pair(acdn_pkg::OP_VOXEL_PAIR, 0, 0, 0, 0, -1, 0, 0, 0, 0);
    send_pair(acdn_pkg::OP_VOXEL_PAIR, 0, 0, 0, 3, 0, 0, 0, 0, 0);
    send_pair(acdn_pkg::OP_BOX_PAIR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(OP_SPARE, 10, -20, 30, -40, 50, -60, 70, 80, 90);
    send_pair(OP_SPARE, 1, 2, 3, 1, 2, 3, EMAX, 1, 2);
    send_pair(acdn_pkg::OP_VOXEL_BOX, 24'sh555555, -24'sh2AAAAB, 0, 0, 0, 0,
              22'h155555, 22'h2AAAAA, 1);
  endtask

  // Random pairs: mostly nearby boxes so contacts overlap, some far apart.
  task automatic test_random(int count);
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
    logic [1:0] op;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(19) == 0) ? OP_SPARE : 2'($urandom_range(2));
      ax = rand_coord(); ay = rand_coord(); az = rand_coord();
      if ($urandom_range(3) != 0) begin
        bx = near_coord(ax);
        by = near_coord(ay);
        bz = near_coord(az);
        if ($urandom_range(29) == 0) begin bx = ax; by = ay; bz = az; end
        send_pair(op, ax, ay, az, bx, by, bz, EW'($urandom_range(1024)),
                  EW'($urandom_range(1024)), EW'($urandom_range(1024)));
      end else begin
        send_pair(op, ax, ay, az, rand_coord(), rand_coord(), rand_coord(),
                  EW'($urandom), EW'($urandom), EW'($urandom));
      end
    end
  endtask

  // Full-rate traffic with neither side ever holding back.
  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    test_random(count);
    no_idle = 1'b0;
  endtask

  initial begin
    int guard;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(700);
    test_back_to_back(200);
    test_random(600);
    in_valid <= 1'b0;
    guard = 0;
    while (pending_contacts.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_contacts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Generous ceiling on the whole run in case the block stops responding.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
